>>> hw/rtl/ibus_rc_frame_decoder_defines.svh
// Assertion macros used by the decoder's checker.
`ifndef IBUS_RC_FRAME_DECODER_DEFINES_SVH
`define IBUS_RC_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define IBRC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ibus_rc_frame_decoder: check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define IBRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ibus_rc_frame_decoder: check failed");

`endif

>>> hw/rtl/ibrc_pkg.sv
package ibrc_pkg;

  localparam int CHAN_W  = 16;
  localparam int USED_CH = 10;
  localparam int BYTE_W  = 8;

  localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h20;
  localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h40;
  localparam logic [CHAN_W-1:0] SUM_ALL_ONES = 16'hFFFF;
  localparam logic [CHAN_W-1:0] FAILSAFE_RESET = 16'd1020;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FAILSAFE = 1'b0;

  typedef logic [USED_CH-1:0][CHAN_W-1:0] chan_array_t;

  typedef struct packed {
    logic emit;
    logic status;
    logic latch;
  } parse_evt_t;

endpackage

>>> hw/rtl/ibrc_parser.sv
module ibrc_parser #(
  parameter int FRAME_CHANNELS = 14
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [ibrc_pkg::BYTE_W-1:0]  rx_byte,
  input  logic                         link_timeout,
  input  logic [ibrc_pkg::CHAN_W-1:0]  threshold,
  output ibrc_pkg::parse_evt_t         evt,
  output ibrc_pkg::chan_array_t        staged
);
  import ibrc_pkg::*;

  localparam int PAY_BYTES = 2 * FRAME_CHANNELS;
  localparam int IDX_W = $clog2(PAY_BYTES + 1);

  typedef enum logic [3:0] {
    PH_HUNT    = 4'b0001,
    PH_HEADER  = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_TRAILER = 4'b1000
  } phase_t;

  phase_t             phase, phase_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic [IDX_W:0]     idx_inc;
  logic [CHAN_W-1:0]  sum, sum_next;
  logic [BYTE_W-1:0]  pending, pending_next;
  logic [CHAN_W-1:0]  trailer;
  logic               sum_ok, failsafe;

  assign idx_inc  = {1'b0, idx} + 1'b1;
  assign trailer  = {rx_byte, pending};
  assign sum_ok   = (trailer == (SUM_ALL_ONES - sum));
  assign failsafe = (staged[0] < threshold) && (staged[1] < threshold) &&
                    (staged[2] < threshold) && (staged[3] < threshold);

  always_comb begin
    phase_next   = phase;
    idx_next     = idx;
    sum_next     = sum;
    pending_next = pending;
    evt          = '0;
    if (link_timeout) begin
      phase_next = PH_HUNT;
      idx_next   = '0;
      evt.emit   = 1'b1;
      evt.status = 1'b1;
    end else begin
      case (phase)
        PH_HUNT: begin
          if (rx_byte == HDR_FIRST) phase_next = PH_HEADER;
        end
        PH_HEADER: begin
          if (rx_byte == HDR_SECOND) begin
            phase_next = PH_PAYLOAD;
            idx_next   = '0;
            sum_next   = CHAN_W'(HDR_FIRST) + CHAN_W'(HDR_SECOND);
          end else if (rx_byte != HDR_FIRST) begin
            phase_next = PH_HUNT;
          end
        end
        PH_PAYLOAD: begin
          sum_next = sum + CHAN_W'(rx_byte);
          if (!idx[0]) pending_next = rx_byte;
          if (idx_inc >= (IDX_W+1)'(PAY_BYTES)) begin
            phase_next = PH_TRAILER;
            idx_next   = '0;
          end else begin
            idx_next = idx_inc[IDX_W-1:0];
          end
        end
        PH_TRAILER: begin
          if (idx == '0) begin
            pending_next = rx_byte;
            idx_next     = IDX_W'(1);
          end else begin
            phase_next = PH_HUNT;
            idx_next   = '0;
            evt.emit   = 1'b1;
            evt.status = !sum_ok || failsafe;
            evt.latch  = sum_ok && !failsafe;
          end
        end
        default: begin
          phase_next = PH_HUNT;
          idx_next   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HUNT;
      idx     <= '0;
      sum     <= '0;
      pending <= '0;
    end else if (step) begin
      phase   <= phase_next;
      idx     <= idx_next;
      sum     <= sum_next;
      pending <= pending_next;
    end
  end

  // staged channels: written by every frame before its trailer, no reset
  always_ff @(posedge clk) begin
    for (int k = 0; k < USED_CH; k++) begin
      if (step && !link_timeout && (phase == PH_PAYLOAD) && idx[0] &&
          (idx[IDX_W-1:1] == (IDX_W-1)'(k))) begin
        staged[k] <= {rx_byte, pending};
      end
    end
  end

endmodule

>>> hw/rtl/ibus_rc_frame_decoder.sv
// channel  handshake                      payload
// cfg      APB psel/penable/pwrite        paddr[2:0], pwdata, prdata
// in       in_valid / in_ready            rx_byte, link_timeout
// out      out_valid / out_ready          link_status, ten channel values
//
// One item per cycle while the result register is free; an item is held in the
// input register, then its result in the result register.
// rst is synchronous: parser hunts, held channels zero, threshold 1020.
// A stalled result holds the result register; the input register still
// takes an item and waits behind it, so in_ready drops only when both are full.
module ibus_rc_frame_decoder #(
  parameter int FRAME_CHANNELS = 14
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ibrc_pkg::BYTE_W-1:0]  rx_byte,
  input  logic                         link_timeout,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         link_status,
  output logic [ibrc_pkg::CHAN_W-1:0]  roll_value,
  output logic [ibrc_pkg::CHAN_W-1:0]  pitch_value,
  output logic [ibrc_pkg::CHAN_W-1:0]  throttle_value,
  output logic [ibrc_pkg::CHAN_W-1:0]  yaw_value,
  output logic [ibrc_pkg::CHAN_W-1:0]  knob_a_value,
  output logic [ibrc_pkg::CHAN_W-1:0]  knob_b_value,
  output logic [ibrc_pkg::CHAN_W-1:0]  switch_a_value,
  output logic [ibrc_pkg::CHAN_W-1:0]  switch_b_value,
  output logic [ibrc_pkg::CHAN_W-1:0]  switch_c_value,
  output logic [ibrc_pkg::CHAN_W-1:0]  switch_d_value
);
  import ibrc_pkg::*;

  logic [CHAN_W-1:0] threshold;
  logic [CFG_IDX_W-1:0] cfg_idx;

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_timeout;
  logic              out_free, s1_step;

  parse_evt_t        evt;
  chan_array_t       staged;
  chan_array_t       held, held_next;
  chan_array_t       res_chan;
  logic              res_status;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[2];
  assign prdata  = (cfg_idx == REG_FAILSAFE) ? {16'b0, threshold} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= FAILSAFE_RESET;
    end else if (psel && penable && pwrite && pready && cfg_idx == REG_FAILSAFE) begin
      threshold <= pwdata[CHAN_W-1:0];
    end
  end

  assign out_free = !out_valid || out_ready;
  assign s1_step  = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte    <= rx_byte;
      s1_timeout <= link_timeout;
    end
  end

  ibrc_parser #(
    .FRAME_CHANNELS(FRAME_CHANNELS)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (s1_step),
    .rx_byte      (s1_byte),
    .link_timeout (s1_timeout),
    .threshold    (threshold),
    .evt          (evt),
    .staged       (staged)
  );

  assign held_next = evt.latch ? staged : held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (s1_step) begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_step && evt.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_step && evt.emit) begin
      res_status <= evt.status;
      res_chan   <= held_next;
    end
  end

  assign link_status    = res_status;
  assign roll_value     = res_chan[0];
  assign pitch_value    = res_chan[1];
  assign throttle_value = res_chan[2];
  assign yaw_value      = res_chan[3];
  assign knob_a_value   = res_chan[4];
  assign knob_b_value   = res_chan[5];
  assign switch_a_value = res_chan[6];
  assign switch_b_value = res_chan[7];
  assign switch_c_value = res_chan[8];
  assign switch_d_value = res_chan[9];

endmodule

>>> hw/rtl/ibrc_checker.sv
`include "ibus_rc_frame_decoder_defines.svh"

module ibrc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         psel,
  input logic                         pready,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         link_timeout,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         link_status,
  input logic [ibrc_pkg::CHAN_W-1:0]  roll_value,
  input logic [ibrc_pkg::CHAN_W-1:0]  switch_d_value
);

  `IBRC_ASSERT_NOW(a_pready_high, psel, pready)

  `IBRC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(link_status) && $stable(roll_value) && $stable(switch_d_value))

  `IBRC_ASSERT_NOW(a_in_stall_cause, !in_ready, out_valid && !out_ready)

  `IBRC_ASSERT_NEXT(a_timeout_result, in_valid && in_ready && link_timeout, ##1 out_valid)

endmodule

bind ibus_rc_frame_decoder ibrc_checker u_ibrc_checker (.*);

>>> tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ibrc_pkg::*;

  localparam int FRAME_CH = 14;
  localparam int ITEM_TARGET = 900;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] ADDR_THRESHOLD = {REG_FAILSAFE, 2'b00};
  localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

  typedef struct packed {
    logic        status;
    chan_array_t chans;
  } link_report_t;

  typedef enum logic [1:0] {HUNT, HEADER, PAYLOAD, TRAILER} parse_phase_e;
  typedef enum {GOOD_FRAME, BAD_SUM_FRAME, FAILSAFE_FRAME, CUT_FRAME} frame_kind_e;

  class rc_link_tracker;
    logic [15:0]  threshold;
    parse_phase_e phase;
    logic [4:0]   byte_idx;
    logic [15:0]  sum;
    logic [7:0]   low_byte;
    chan_array_t  staged;
    chan_array_t  held;
    link_report_t due_reports[$];
    int           fail_count;
    string        chan_names[USED_CH] = '{"roll_value", "pitch_value", "throttle_value",
      "yaw_value", "knob_a_value", "knob_b_value", "switch_a_value", "switch_b_value",
      "switch_c_value", "switch_d_value"};

    function new();
      threshold = FAILSAFE_RESET;
      phase = HUNT;
      byte_idx = '0;
      sum = '0;
      low_byte = '0;
      staged = '0;
      held = '0;
      fail_count = 0;
    endfunction

    function void write_reg(logic [2:0] addr, logic [31:0] data);
      if (addr[2] == REG_FAILSAFE && addr[1:0] == 2'b00) threshold = data[15:0];
    endfunction

    function void report(logic status);
      link_report_t r;
      r.status = status;
      r.chans = held;
      due_reports.push_back(r);
    endfunction

    function void take_byte(logic [7:0] b, logic timeout);
      logic [15:0] trailer;
      if (timeout) begin
        phase = HUNT;
        byte_idx = '0;
        report(1'b1);
        return;
      end
      case (phase)
        HUNT: begin
          if (b == HDR_FIRST) phase = HEADER;
        end
        HEADER: begin
          if (b == HDR_SECOND) begin
            phase = PAYLOAD;
            byte_idx = '0;
            sum = 16'(HDR_FIRST) + 16'(HDR_SECOND);
          end else if (b != HDR_FIRST) begin
            phase = HUNT;
          end
        end
        PAYLOAD: begin
          sum = sum + 16'(b);
          if (!byte_idx[0]) low_byte = b;
          else if (byte_idx[4:1] < USED_CH) staged[byte_idx[4:1]] = {b, low_byte};
          byte_idx = byte_idx + 5'd1;
          if (byte_idx >= 2 * FRAME_CH) begin
            phase = TRAILER;
            byte_idx = '0;
          end
        end
        TRAILER: begin
          if (byte_idx == 0) begin
            low_byte = b;
            byte_idx = 5'd1;
          end else begin
            trailer = {b, low_byte};
            phase = HUNT;
            byte_idx = '0;
            if (trailer != SUM_ALL_ONES - sum) report(1'b1);
            else if (staged[0] < threshold && staged[1] < threshold &&
                     staged[2] < threshold && staged[3] < threshold) report(1'b1);
            else begin
              held = staged;
              report(1'b0);
            end
          end
        end
      endcase
    endfunction

    function void check_report(logic status, chan_array_t chans);
      link_report_t want;
      if (due_reports.size() == 0) begin
        $error("unexpected result: link_status %0d", status);
        fail_count++;
        return;
      end
      want = due_reports.pop_front();
      if (status !== want.status) begin
        $error("link_status: expected %0d, got %0d", want.status, status);
        fail_count++;
      end
      for (int k = 0; k < USED_CH; k++) begin
        if (chans[k] !== want.chans[k]) begin
          $error("%s: expected 0x%04h, got 0x%04h", chan_names[k], want.chans[k], chans[k]);
          fail_count++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] rx_byte = '0;
  logic link_timeout = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic link_status;
  logic [15:0] roll_value, pitch_value, throttle_value, yaw_value, knob_a_value;
  logic [15:0] knob_b_value, switch_a_value, switch_b_value, switch_c_value, switch_d_value;
  chan_array_t out_chans;

  rc_link_tracker board;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int cycles = 0;

  assign out_chans = {switch_d_value, switch_c_value, switch_b_value, switch_a_value,
                      knob_b_value, knob_a_value, yaw_value, throttle_value,
                      pitch_value, roll_value};

  ibus_rc_frame_decoder #(.FRAME_CHANNELS(FRAME_CH)) DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte), .link_timeout(link_timeout),
    .out_valid(out_valid), .out_ready(out_ready), .link_status(link_status),
    .roll_value(roll_value), .pitch_value(pitch_value), .throttle_value(throttle_value),
    .yaw_value(yaw_value), .knob_a_value(knob_a_value), .knob_b_value(knob_b_value),
    .switch_a_value(switch_a_value), .switch_b_value(switch_b_value),
    .switch_c_value(switch_c_value), .switch_d_value(switch_d_value)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_report(link_status, out_chans);
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic int pick_gap();
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    return gap;
  endfunction

  task automatic send_item(logic [7:0] b, logic timeout);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    link_timeout <= timeout;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_byte(b, timeout);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.due_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    board.write_reg(addr, data);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_check_threshold();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_THRESHOLD;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== 32'(board.threshold)) begin
      $error("failsafe_threshold: expected 0x%08h, got 0x%08h", 32'(board.threshold), prdata);
      board.fail_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [15:0] pick_chan(bit below);
    logic [15:0] t;
    t = board.threshold;
    if (below && t != 0) return 16'($urandom_range(t - 1, 0));
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return t;
      3: return t - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_frame(frame_kind_e kind);
    logic [7:0] bytes[$];
    logic [15:0] sum;
    logic [15:0] v;
    int cut;
    if ($urandom_range(5) == 0) repeat ($urandom_range(2, 1)) bytes.push_back(HDR_FIRST);
    bytes.push_back(HDR_FIRST);
    bytes.push_back(HDR_SECOND);
    sum = 16'(HDR_FIRST) + 16'(HDR_SECOND);
    for (int c = 0; c < FRAME_CH; c++) begin
      v = pick_chan(kind == FAILSAFE_FRAME && c < 4);
      bytes.push_back(v[7:0]);
      bytes.push_back(v[15:8]);
      sum = sum + 16'(v[7:0]) + 16'(v[15:8]);
    end
    v = SUM_ALL_ONES - sum;
    if (kind == BAD_SUM_FRAME) v = v ^ (16'd1 << $urandom_range(15));
    bytes.push_back(v[7:0]);
    bytes.push_back(v[15:8]);
    cut = (kind == CUT_FRAME) ? $urandom_range(bytes.size() - 1, 1) : bytes.size();
    for (int i = 0; i < cut; i++) send_item(bytes[i], 1'b0);
    if (kind == CUT_FRAME) send_item(8'($urandom), 1'b1);
  endtask

  task automatic send_random_piece();
    int r;
    r = $urandom_range(99);
    if (r < 8) begin
      send_item(8'($urandom), 1'b1);
    end else if (r < 20) begin
      repeat ($urandom_range(5, 1))
        send_item(($urandom_range(3) == 0) ? HDR_FIRST : 8'($urandom), 1'b0);
    end else begin
      r = $urandom_range(99);
      if (r < 50) send_frame(GOOD_FRAME);
      else if (r < 70) send_frame(BAD_SUM_FRAME);
      else if (r < 85) send_frame(FAILSAFE_FRAME);
      else send_frame(CUT_FRAME);
    end
  endtask

  initial begin
    logic [15:0] thr_plan[4];
    int base;
    board = new();
    thr_plan[0] = 16'd0;
    thr_plan[1] = 16'hFFFF;
    thr_plan[2] = 16'($urandom_range(40000, 2000));
    thr_plan[3] = FAILSAFE_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    apb_check_threshold();
    apb_write(ADDR_UNMAPPED, 32'h0000_1234);
    apb_check_threshold();

    // timeout in the hunt, header and payload phases, repeated and broken headers, stray bytes
    send_item(8'hFF, 1'b1);
    send_item(HDR_FIRST, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(HDR_FIRST, 1'b0);
    send_item(HDR_FIRST, 1'b0);
    send_item(HDR_FIRST, 1'b0);
    send_item(HDR_SECOND, 1'b0);
    send_item(8'hA5, 1'b0);
    send_item(8'h5A, 1'b1);
    send_item(HDR_FIRST, 1'b0);
    send_item(8'h41, 1'b0);
    send_item(HDR_SECOND, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    base = items_sent;

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      apb_write(ADDR_THRESHOLD, {16'($urandom), thr_plan[ph]});
      apb_check_threshold();
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      while (items_sent < base + ITEM_TARGET * (ph + 1) / 4) send_random_piece();
    end

    in_valid <= 1'b0;
    while (board.due_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/ibrc_pkg.sv
hw/rtl/ibrc_parser.sv
hw/rtl/ibus_rc_frame_decoder.sv
hw/rtl/ibrc_checker.sv
tb/tb_top.sv
